// ===== rtl/rbsi_pkg.sv =====
`timescale 1ns / 1ps

package rbsi_pkg;

  // reciprocal divider geometry
  localparam int RCP_QBITS     = 27;
  localparam int DIV_PER_STAGE = 4;
  localparam int DIV_STAGES    = (RCP_QBITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  // stage latencies and positions along the main pipeline
  localparam int RCP_LAT  = DIV_STAGES + 3;
  localparam int MUL_LAT  = 3;
  localparam int SUB_LAT  = 4;
  localparam int ST_MUL   = RCP_LAT;
  localparam int ST_SUB   = ST_MUL + MUL_LAT;
  localparam int ST_LO    = ST_SUB + SUB_LAT;
  localparam int ST_RA    = ST_LO + 1;
  localparam int ST_RB    = ST_RA + 1;
  localparam int ST_LIM   = ST_RB + 1;
  localparam int ST_OUT   = ST_LIM + 1;
  localparam int N_STAGES = ST_OUT + 1;

  localparam logic [31:0] F_QNAN     = 32'h7FC00000;
  localparam logic [31:0] F_MISS     = 32'hBF800000;
  localparam logic [31:0] F_INF      = 32'h7F800000;
  localparam logic [30:0] RCP_FLOOR  = 31'h322BCC77;

  typedef struct packed {
    logic [31:0] origin_x;
    logic [31:0] origin_y;
    logic [31:0] origin_z;
    logic [31:0] dir_x;
    logic [31:0] dir_y;
    logic [31:0] dir_z;
    logic [31:0] box_min_x;
    logic [31:0] box_min_y;
    logic [31:0] box_min_z;
    logic [31:0] box_max_x;
    logic [31:0] box_max_y;
    logic [31:0] box_max_z;
  } rbsi_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] entry_distance;
  } rbsi_out_t;

  // unrounded result: msb of mant at bit 47 means biased exponent tot
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] tot;
    logic [47:0]        mant;
    logic               sticky;
  } rbsi_unr_t;

  // normalised or denormalised significand ready for rounding
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] e;
    logic [47:0]        mant;
    logic               sticky;
  } rbsi_nrm_t;

  function automatic logic f_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic f_inf(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
  endfunction

  // ordered less-than, operands not nan, +0 equals -0
  function automatic logic f_lt(logic [31:0] a, logic [31:0] b);
    logic lt;
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      lt = 1'b0;
    end else if (a[31] != b[31]) begin
      lt = a[31];
    end else if (!a[31]) begin
      lt = a[30:0] < b[30:0];
    end else begin
      lt = a[30:0] > b[30:0];
    end
    return lt;
  endfunction

  function automatic logic [31:0] f_max(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    if (f_nan(b)) begin
      r = f_nan(a) ? b : a;
    end else if (f_nan(a)) begin
      r = b;
    end else begin
      r = f_lt(a, b) ? b : a;
    end
    return r;
  endfunction

  function automatic logic [31:0] f_min(logic [31:0] a, logic [31:0] b);
    logic [31:0] r;
    if (f_nan(b)) begin
      r = f_nan(a) ? b : a;
    end else if (f_nan(a)) begin
      r = b;
    end else begin
      r = f_lt(b, a) ? b : a;
    end
    return r;
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] m);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (m[i]) begin
        lz = 6'(47 - i);
      end
    end
    return lz;
  endfunction

  // leading-one shift, or right shift into the subnormal range
  function automatic rbsi_nrm_t f_norm(rbsi_unr_t u);
    logic [5:0]         lz;
    logic signed [10:0] lzs;
    logic signed [10:0] amt;
    logic [5:0]         sh;
    logic [95:0]        wide;
    rbsi_nrm_t          n;
    lz         = lzc48(u.mant);
    lzs        = {5'd0, lz};
    n.spec     = u.spec;
    n.spec_val = u.spec_val;
    n.sign     = u.sign;
    n.sticky   = u.sticky;
    n.e        = 11'sd1;
    n.mant     = u.mant;
    if (u.tot - lzs >= 11'sd1) begin
      n.mant = u.mant << lz;
      n.e    = u.tot - lzs;
    end else if (u.tot >= 11'sd1) begin
      amt    = u.tot - 11'sd1;
      n.mant = u.mant << amt[5:0];
    end else begin
      amt      = 11'sd1 - u.tot;
      sh       = (amt > 11'sd63) ? 6'd63 : amt[5:0];
      wide     = {u.mant, 48'd0} >> sh;
      n.mant   = wide[95:48];
      n.sticky = u.sticky | (|wide[47:0]);
    end
    return n;
  endfunction

  // round to nearest even and pack
  function automatic logic [31:0] f_pack(rbsi_nrm_t n);
    logic               up;
    logic [24:0]        m25;
    logic signed [10:0] fld;
    logic [22:0]        frac;
    logic [31:0]        r;
    up  = n.mant[23] & ((|n.mant[22:0]) | n.sticky | n.mant[24]);
    m25 = {1'b0, n.mant[47:24]} + {24'd0, up};
    if (m25[24]) begin
      fld  = n.e + 11'sd1;
      frac = 23'd0;
    end else begin
      fld  = m25[23] ? n.e : 11'sd0;
      frac = m25[22:0];
    end
    if (n.spec) begin
      r = n.spec_val;
    end else if (fld >= 11'sd255) begin
      r = {n.sign, F_INF[30:0]};
    end else begin
      r = {n.sign, fld[7:0], frac};
    end
    return r;
  endfunction

endpackage

// ===== rtl/rbsi_round.sv =====
`timescale 1ns / 1ps

module rbsi_round import rbsi_pkg::*; (
  input  logic        clk,
  input  logic [1:0]  en,
  input  rbsi_unr_t   unr,
  output logic [31:0] res
);

  rbsi_nrm_t   nrm_r;
  logic [31:0] res_r;

  // normalise, then round and pack
  always_ff @(posedge clk) begin
    if (en[0]) begin
      nrm_r <= f_norm(unr);
    end
    if (en[1]) begin
      res_r <= f_pack(nrm_r);
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/rbsi_rcp.sv =====
`timescale 1ns / 1ps

module rbsi_rcp import rbsi_pkg::*; (
  input  logic               clk,
  input  logic [RCP_LAT-1:0] en,
  input  logic [31:0]        dir,
  output logic [31:0]        inv
);

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic [7:0]  e;
    logic [23:0] m;
    logic [24:0] r;
    logic [26:0] q;
  } div_t;

  div_t      st_r [DIV_STAGES+1];
  div_t      prep;
  rbsi_unr_t unr;
  logic [31:0] dd;

  // restoring division steps of 1.0 by the significand
  function automatic div_t div_step(div_t x, int base);
    div_t y;
    logic qb;
    y = x;
    for (int k = 0; k < DIV_PER_STAGE; k++) begin
      if (base + k < RCP_QBITS) begin
        qb = y.r >= {1'b0, y.m};
        if (qb) begin
          y.r = y.r - {1'b0, y.m};
        end
        y.q = {y.q[25:0], qb};
        y.r = {y.r[23:0], 1'b0};
      end
    end
    return y;
  endfunction

  // tiny magnitudes clamp to a signed floor, zero counts as positive
  always_comb begin
    if (dir[30:0] < RCP_FLOOR) begin
      dd = {dir[31] && (dir[30:0] != 31'd0), RCP_FLOOR};
    end else begin
      dd = dir;
    end
    prep.spec     = f_nan(dd) || f_inf(dd);
    prep.spec_val = f_nan(dd) ? F_QNAN : {dd[31], 31'd0};
    prep.sign     = dd[31];
    prep.e        = dd[30:23];
    prep.m        = {1'b1, dd[22:0]};
    prep.r        = 25'h0800000;
    prep.q        = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st_r[0] <= prep;
    end
  end

  for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[g]) begin
        st_r[g] <= div_step(st_r[g-1], (g - 1) * DIV_PER_STAGE);
      end
    end
  end

  // quotient bit 26 weighs 1.0, exponent of result is 254 - e
  always_comb begin
    unr.spec     = st_r[DIV_STAGES].spec;
    unr.spec_val = st_r[DIV_STAGES].spec_val;
    unr.sign     = st_r[DIV_STAGES].sign;
    unr.tot      = 11'sd254 - $signed({3'd0, st_r[DIV_STAGES].e});
    unr.mant     = {st_r[DIV_STAGES].q, 21'd0};
    unr.sticky   = st_r[DIV_STAGES].r != 25'd0;
  end

  rbsi_round u_round (
    .clk (clk),
    .en  (en[RCP_LAT-1:RCP_LAT-2]),
    .unr (unr),
    .res (inv)
  );

endmodule

// ===== rtl/rbsi_fmul.sv =====
`timescale 1ns / 1ps

module rbsi_fmul import rbsi_pkg::*; (
  input  logic               clk,
  input  logic [MUL_LAT-1:0] en,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        res
);

  rbsi_unr_t   unr_nxt;
  rbsi_unr_t   unr_r;
  logic        sgn;
  logic        za;
  logic        zb;
  logic [7:0]  ea;
  logic [7:0]  eb;

  // special operands and the raw significand product
  always_comb begin
    sgn = a[31] ^ b[31];
    za  = a[30:0] == 31'd0;
    zb  = b[30:0] == 31'd0;
    ea  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    unr_nxt.sign     = sgn;
    unr_nxt.sticky   = 1'b0;
    unr_nxt.mant     = {a[30:23] != 8'd0, a[22:0]} * {b[30:23] != 8'd0, b[22:0]};
    unr_nxt.tot      = $signed({3'd0, ea}) + $signed({3'd0, eb}) - 11'sd126;
    unr_nxt.spec     = 1'b1;
    if (f_nan(a) || f_nan(b) || (f_inf(a) && zb) || (f_inf(b) && za)) begin
      unr_nxt.spec_val = F_QNAN;
    end else if (f_inf(a) || f_inf(b)) begin
      unr_nxt.spec_val = {sgn, F_INF[30:0]};
    end else if (za || zb) begin
      unr_nxt.spec_val = {sgn, 31'd0};
    end else begin
      unr_nxt.spec     = 1'b0;
      unr_nxt.spec_val = F_QNAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      unr_r <= unr_nxt;
    end
  end

  rbsi_round u_round (
    .clk (clk),
    .en  (en[2:1]),
    .unr (unr_r),
    .res (res)
  );

endmodule

// ===== rtl/rbsi_fsub.sv =====
`timescale 1ns / 1ps

module rbsi_fsub import rbsi_pkg::*; (
  input  logic               clk,
  input  logic [SUB_LAT-1:0] en,
  input  logic [31:0]        a,
  input  logic [31:0]        b,
  output logic [31:0]        res
);

  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        sign;
    logic        sub;
    logic [7:0]  e;
    logic [26:0] ma;
    logic [26:0] mb;
  } aln_t;

  aln_t        aln_nxt;
  aln_t        aln_r;
  rbsi_unr_t   unr_nxt;
  rbsi_unr_t   unr_r;
  logic [31:0] bn;
  logic [31:0] x;
  logic [31:0] y;
  logic [7:0]  ex;
  logic [7:0]  ey;
  logic [7:0]  d;
  logic [4:0]  dc;
  logic [53:0] wide;
  logic [27:0] sum;

  // order by magnitude and align the smaller operand, sticky in bit 0
  always_comb begin
    bn   = {~b[31], b[30:0]};
    x    = (bn[30:0] > a[30:0]) ? bn : a;
    y    = (bn[30:0] > a[30:0]) ? a : bn;
    ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d    = ex - ey;
    dc   = (d > 8'd27) ? 5'd27 : d[4:0];
    wide = {y[30:23] != 8'd0, y[22:0], 3'd0, 27'd0} >> dc;
    aln_nxt.sign = x[31];
    aln_nxt.sub  = x[31] ^ y[31];
    aln_nxt.e    = ex;
    aln_nxt.ma   = {x[30:23] != 8'd0, x[22:0], 3'd0};
    aln_nxt.mb   = {wide[53:28], wide[27] | (|wide[26:0])};
    aln_nxt.spec = 1'b1;
    if (f_nan(a) || f_nan(b) || (f_inf(a) && f_inf(bn) && (a[31] != bn[31]))) begin
      aln_nxt.spec_val = F_QNAN;
    end else if (f_inf(a)) begin
      aln_nxt.spec_val = a;
    end else if (f_inf(bn)) begin
      aln_nxt.spec_val = bn;
    end else begin
      aln_nxt.spec     = 1'b0;
      aln_nxt.spec_val = F_QNAN;
    end
  end

  // significand add or subtract; an exact zero is +0 unless a is -0 and b is +0
  always_comb begin
    sum = aln_r.sub ? ({1'b0, aln_r.ma} - {1'b0, aln_r.mb})
                    : ({1'b0, aln_r.ma} + {1'b0, aln_r.mb});
    unr_nxt.sign     = aln_r.sign;
    unr_nxt.sticky   = 1'b0;
    unr_nxt.mant     = {sum, 20'd0};
    unr_nxt.tot      = $signed({3'd0, aln_r.e}) + 11'sd1;
    unr_nxt.spec     = aln_r.spec || (sum == 28'd0);
    unr_nxt.spec_val = aln_r.spec ? aln_r.spec_val
                                  : {aln_r.sign & ~aln_r.sub, 31'd0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      aln_r <= aln_nxt;
    end
    if (en[1]) begin
      unr_r <= unr_nxt;
    end
  end

  rbsi_round u_round (
    .clk (clk),
    .en  (en[3:2]),
    .unr (unr_r),
    .res (res)
  );

endmodule

// ===== rtl/ray_box_slab_intersect_unit.sv =====
`timescale 1ns / 1ps
// channel  | ports                                      | transfer when
// ---------+--------------------------------------------+---------------------------
// input    | in_valid, in_ready, in_data (rbsi_in_t)    | in_valid && in_ready
// result   | out_valid, out_ready, out_data (rbsi_out_t)| out_valid && out_ready
// config   | psel, penable, pwrite, paddr, pwdata, ...  | psel && penable && pwrite
//
// one ray-box test enters per cycle while in_ready is high; the pipeline holds the
// reciprocal divider (4 quotient bits per stage), three multiply and four subtract stages
// rst_n is synchronous, clears the valid bits and resets the limit registers (near 0, far +inf)
// each stage holds its item while the next stage cannot move, so stalls fill bubbles first

module ray_box_slab_intersect_unit import rbsi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  rbsi_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rbsi_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_NEAR = 1'b0;
  localparam logic REG_FAR  = 1'b1;

  typedef struct packed {
    logic [2:0][31:0] org;
    logic [2:0][31:0] bmn;
    logic [2:0][31:0] bmx;
  } car_t;

  logic [N_STAGES-1:0] vld_r;
  logic [N_STAGES-1:0] en;
  logic [31:0]         near_r;
  logic [31:0]         far_r;
  car_t                car_r [RCP_LAT];
  car_t                car_nxt;
  logic [2:0][31:0]    dir;
  logic [2:0][31:0]    inv;
  logic [2:0][31:0]    os;
  logic [2:0][31:0]    p0;
  logic [2:0][31:0]    p1;
  logic [2:0][31:0]    t0;
  logic [2:0][31:0]    t1;
  logic [2:0][31:0]    lo_r;
  logic [2:0][31:0]    hi_r;
  logic [31:0]         m1_r;
  logic [31:0]         n1_r;
  logic [31:0]         lo2_r;
  logic [31:0]         hi2_r;
  logic [31:0]         ent0_r;
  logic [31:0]         ext0_r;
  logic [31:0]         ent_r;
  logic [31:0]         ext_r;
  rbsi_out_t           out_r;
  rbsi_out_t           out_nxt;

  // config registers
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FAR) ? far_r : near_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 32'd0;
      far_r  <= F_INF;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_NEAR: near_r <= pwdata;
        REG_FAR:  far_r  <= pwdata;
        default:  near_r <= near_r;
      endcase
    end
  end

  // per-stage advance: a stage moves when empty or when the next one moves
  always_comb begin
    en[N_STAGES-1] = !vld_r[N_STAGES-1] || out_ready;
    for (int i = N_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[N_STAGES-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < N_STAGES; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // operands that wait alongside the reciprocal
  always_comb begin
    car_nxt.org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
    car_nxt.bmn = {in_data.box_min_z, in_data.box_min_y, in_data.box_min_x};
    car_nxt.bmx = {in_data.box_max_z, in_data.box_max_y, in_data.box_max_x};
    dir         = {in_data.dir_z, in_data.dir_y, in_data.dir_x};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      car_r[0] <= car_nxt;
    end
    for (int i = 1; i < RCP_LAT; i++) begin
      if (en[i]) begin
        car_r[i] <= car_r[i-1];
      end
    end
  end

  // per-axis reciprocal, products and slab distances
  for (genvar ax = 0; ax < 3; ax++) begin : g_axis
    rbsi_rcp u_rcp (
      .clk (clk),
      .en  (en[RCP_LAT-1:0]),
      .dir (dir[ax]),
      .inv (inv[ax])
    );

    rbsi_fmul u_mul_o (
      .clk (clk),
      .en  (en[ST_MUL +: MUL_LAT]),
      .a   (car_r[RCP_LAT-1].org[ax]),
      .b   (inv[ax]),
      .res (os[ax])
    );

    rbsi_fmul u_mul_lo (
      .clk (clk),
      .en  (en[ST_MUL +: MUL_LAT]),
      .a   (car_r[RCP_LAT-1].bmn[ax]),
      .b   (inv[ax]),
      .res (p0[ax])
    );

    rbsi_fmul u_mul_hi (
      .clk (clk),
      .en  (en[ST_MUL +: MUL_LAT]),
      .a   (car_r[RCP_LAT-1].bmx[ax]),
      .b   (inv[ax]),
      .res (p1[ax])
    );

    rbsi_fsub u_sub_lo (
      .clk (clk),
      .en  (en[ST_SUB +: SUB_LAT]),
      .a   (p0[ax]),
      .b   (os[ax]),
      .res (t0[ax])
    );

    rbsi_fsub u_sub_hi (
      .clk (clk),
      .en  (en[ST_SUB +: SUB_LAT]),
      .a   (p1[ax]),
      .b   (os[ax]),
      .res (t1[ax])
    );

    // sort the two slab distances
    always_ff @(posedge clk) begin
      if (en[ST_LO]) begin
        lo_r[ax] <= f_min(t0[ax], t1[ax]);
        hi_r[ax] <= f_max(t0[ax], t1[ax]);
      end
    end
  end

  // reduce over the axes, then clamp to the limits
  always_ff @(posedge clk) begin
    if (en[ST_RA]) begin
      m1_r  <= f_max(lo_r[1], lo_r[0]);
      n1_r  <= f_min(hi_r[1], hi_r[0]);
      lo2_r <= lo_r[2];
      hi2_r <= hi_r[2];
    end
    if (en[ST_RB]) begin
      ent0_r <= f_max(m1_r, lo2_r);
      ext0_r <= f_min(n1_r, hi2_r);
    end
    if (en[ST_LIM]) begin
      ent_r <= f_max(ent0_r, near_r);
      ext_r <= f_min(ext0_r, far_r);
    end
    if (en[ST_OUT]) begin
      out_r <= out_nxt;
    end
  end

  // hit when exit lies strictly beyond entry
  always_comb begin
    out_nxt.hit            = !f_nan(ent_r) && !f_nan(ext_r) && f_lt(ent_r, ext_r);
    out_nxt.entry_distance = out_nxt.hit ? ent_r : F_MISS;
  end

endmodule
